@@ rtl/raycast_column_height_macros.svh @@
// Assertion helpers for the raycast column block.
`ifndef RAYCAST_COLUMN_HEIGHT_MACROS_SVH
`define RAYCAST_COLUMN_HEIGHT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define RCH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RCH_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rch_pkg.sv @@
// ----------------------------------------------------------------------------
// rch_pkg
// Shared types, constants and the wall map of the raycast column block.
// ----------------------------------------------------------------------------
package rch_pkg;

  localparam int POS_W   = 16;
  localparam int HEAD_W  = 12;
  localparam int COL_W   = 10;
  localparam int HGT_W   = 12;
  localparam int ROW_W   = 9;
  localparam int STEP_W  = 11;
  localparam int CFG_W   = 16;

  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 16;
  localparam int ACC_W     = 48;
  localparam int MA_W      = 26;
  localparam int MB_W      = 18;
  localparam int TRIG_W    = 16;
  localparam int VEC_W     = 26;

  localparam logic [1:0] CFG_POS_X   = 2'd0;
  localparam logic [1:0] CFG_POS_Y   = 2'd1;
  localparam logic [1:0] CFG_HEADING = 2'd2;

  localparam logic [POS_W-1:0]  POS_RESET     = 16'd8192;
  localparam logic [HEAD_W-1:0] HEADING_RESET = 12'd0;

  // quintic sine coefficients, Q14
  localparam logic [14:0] SIN_C1   = 15'd25736;
  localparam logic [14:0] SIN_C3   = 15'd10512;
  localparam logic [14:0] SIN_C5   = 15'd1160;
  localparam logic [14:0] Q14_ONE  = 15'd16384;
  localparam logic [14:0] Q14_HALF = 15'd8192;
  localparam logic [HEAD_W-1:0] QUARTER_TURN = 12'd1024;

  localparam logic signed [ACC_W-1:0] CELL_SCALE = 48'sd1638400;
  localparam logic [2:0] INTERIOR_END = 3'd7;
  localparam logic [HGT_W-1:0] HGT_MAX = 12'd4095;

  // rows of the map, bit x set means wall; only cells 0..7 can be reached
  localparam logic [7:0] WALL_ROWS [8] = '{
    8'hFF, 8'h01, 8'h0D, 8'h65, 8'h05, 8'h01, 8'h01, 8'h01
  };

  typedef enum logic [4:0] {
    S_IDLE, S_Y1_GO, S_Y1_WAIT, S_U2, S_U3, S_U5, S_S0, S_S1, S_S2, S_SEND,
    S_VX0, S_VX1, S_VY0, S_VY1, S_VEND, S_M_GO, S_MARCH, S_H_GO, S_H_WAIT, S_FIN
  } state_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_op_t;

  function automatic logic [2:0] cell_idx(input logic signed [ACC_W-1:0] s);
    logic [2:0] c;
    c = '0;
    for (int k = 1; k <= 7; k++) begin
      if (s >= $signed(ACC_W'(k)) * CELL_SCALE) c = c + 3'd1;
    end
    return c;
  endfunction

  function automatic logic is_wall(input logic signed [ACC_W-1:0] sx,
                                   input logic signed [ACC_W-1:0] sy);
    logic [2:0] cx;
    logic [2:0] cy;
    logic [7:0] row;
    cx = cell_idx(sx);
    cy = cell_idx(sy);
    row = WALL_ROWS[cy];
    if (cx == 3'd0 || cy == 3'd0 || cx == INTERIOR_END || cy == INTERIOR_END)
      return 1'b1;
    return row[cx];
  endfunction

endpackage

@@ rtl/rch_if.sv @@
// ----------------------------------------------------------------------------
// rch_in_if / rch_out_if
// Valid/ready channels for column requests and wall span results.
// ----------------------------------------------------------------------------
interface rch_in_if;
  logic                       valid;
  logic                       ready;
  logic [rch_pkg::COL_W-1:0]  column;
  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

interface rch_out_if;
  logic                       valid;
  logic                       ready;
  logic [rch_pkg::HGT_W-1:0]  wall_height;
  logic [rch_pkg::ROW_W-1:0]  ceiling_end;
  logic [rch_pkg::ROW_W-1:0]  floor_start;
  logic [rch_pkg::STEP_W-1:0] march_steps;
  modport source (output valid, output wall_height, output ceiling_end,
                  output floor_start, output march_steps, input ready);
  modport sink   (input valid, input wall_height, input ceiling_end,
                  input floor_start, input march_steps, output ready);
endinterface

@@ rtl/rch_divider.sv @@
// ----------------------------------------------------------------------------
// rch_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rch_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rch_pkg::DIV_NUM_W-1:0]  num,
  input  logic [rch_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [rch_pkg::DIV_NUM_W-1:0]  quo
);
  localparam int NW = rch_pkg::DIV_NUM_W;
  localparam int DW = rch_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   shifted;

  always_comb begin
    shifted = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = shifted;
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt  = shifted - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ rtl/rch_mac.sv @@
// ----------------------------------------------------------------------------
// rch_mac
// Shared signed multiply-accumulate unit for the sine and ray setup.
// ----------------------------------------------------------------------------
module rch_mac (
  input  logic                                clk,
  input  rch_pkg::mac_op_t                    op,
  input  logic signed [rch_pkg::MA_W-1:0]     a,
  input  logic signed [rch_pkg::MB_W-1:0]     b,
  output logic signed [rch_pkg::ACC_W-1:0]    acc
);
  localparam int PW = rch_pkg::MA_W + rch_pkg::MB_W;

  logic signed [PW-1:0]               prod;
  logic signed [rch_pkg::ACC_W-1:0]   base, acc_r, acc_nxt;

  always_comb begin
    prod    = a * b;
    base    = op.clr ? '0 : acc_r;
    acc_nxt = op.sub ? base - rch_pkg::ACC_W'(prod) : base + rch_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

@@ rtl/rch_march.sv @@
// ----------------------------------------------------------------------------
// rch_march
// Fixed-step ray marcher: one step and one cell test per cycle.
// ----------------------------------------------------------------------------
module rch_march #(
  parameter int MAX_STEPS = 2047,
  parameter int NW        = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rch_pkg::POS_W-1:0]           pos_x,
  input  logic [rch_pkg::POS_W-1:0]           pos_y,
  input  logic signed [rch_pkg::VEC_W-1:0]    vx,
  input  logic signed [rch_pkg::VEC_W-1:0]    vy,
  output logic                                done,
  output logic [NW-1:0]                       steps
);
  localparam int AW = rch_pkg::ACC_W;

  logic signed [AW-1:0] sx_r, sy_r;
  logic [NW-1:0]        n_r;
  logic                 busy_r, done_r, stop;
  logic [24:0]          px400, py400;

  // pos * 400 = pos * (256 + 128 + 16)
  assign px400 = {1'b0, pos_x, 8'b0} + {2'b0, pos_x, 7'b0} + {5'b0, pos_x, 4'b0};
  assign py400 = {1'b0, pos_y, 8'b0} + {2'b0, pos_y, 7'b0} + {5'b0, pos_y, 4'b0};

  assign stop = rch_pkg::is_wall(sx_r, sy_r) || (n_r == NW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && stop) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sx_r <= $signed(AW'(px400)) + AW'(vx);
      sy_r <= $signed(AW'(py400)) + AW'(vy);
      n_r  <= NW'(1);
    end else if (busy_r && !stop) begin
      sx_r <= sx_r + AW'(vx);
      sy_r <= sy_r + AW'(vy);
      n_r  <= n_r + 1'b1;
    end
  end

  assign done  = done_r;
  assign steps = n_r;
endmodule

@@ rtl/raycast_column_height.sv @@
// ----------------------------------------------------------------------------
// raycast_column_height
// Wall span of one screen column by fixed-step ray marching.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_ch     in   valid/ready    column
// out_ch    out  valid/ready    wall_height, ceiling_end, floor_start, march_steps
// cfg_*     in   cfg_we         cfg_index, cfg_wdata
//
// One item passes from accept to accept through these steps: accept, the
// lateral offset (constant reciprocal multiply), sine and cosine on the
// shared multiply-accumulate unit, the ray direction, the march, the height
// divide and the hand-off.
// Synchronous active-low reset; no clearing pass. A stalled result holds in
// the output register; the next item is taken and waits at hand-off.
// ----------------------------------------------------------------------------
module raycast_column_height #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int MAX_STEPS     = 2047
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rch_in_if.sink                      in_ch,
  rch_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rch_pkg::CFG_W-1:0]   cfg_wdata
);
  localparam int NW      = $clog2(MAX_STEPS + 1);
  localparam int HALF_W  = SCREEN_WIDTH / 2;
  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam int AW      = rch_pkg::ACC_W;
  localparam int DNW     = rch_pkg::DIV_NUM_W;
  localparam int DDW     = rch_pkg::DIV_DEN_W;

  // ceil(2^37 / width): offset * 2^14 / width is exact as (mag * recip) >> 23
  localparam int          Y1_SHIFT = 23;
  localparam logic [36:0] Y1_RECIP =
    37'(((64'd1 << 37) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  rch_pkg::state_t state_r, state_nxt;

  logic [rch_pkg::POS_W-1:0]  pos_x_r, pos_y_r;
  logic [rch_pkg::HEAD_W-1:0] heading_r;
  logic [rch_pkg::COL_W-1:0]  col_r;
  logic                       phase_r;
  logic signed [DNW-1:0]      y1_r;
  logic [14:0]                u2_r, u3_r, u5_r;
  logic signed [rch_pkg::TRIG_W-1:0] sin_r, cos_r;
  logic signed [rch_pkg::VEC_W-1:0]  vx_r, vy_r;
  logic [DNW-1:0]             hq_r;
  logic [NW-1:0]              steps;

  logic                       out_valid_r;
  logic [rch_pkg::HGT_W-1:0]  wall_height_r;
  logic [rch_pkg::ROW_W-1:0]  ceiling_end_r, floor_start_r;
  logic [rch_pkg::STEP_W-1:0] march_steps_r;

  rch_pkg::mac_op_t           mac_op;
  logic signed [rch_pkg::MA_W-1:0] mac_a;
  logic signed [rch_pkg::MB_W-1:0] mac_b;
  logic signed [AW-1:0]       acc;

  logic                       div_start, div_done, march_start, march_done;
  logic [DNW-1:0]             div_num, div_quo;
  logic [DDW-1:0]             div_den;

  logic                       in_fire, out_free;
  logic [rch_pkg::HEAD_W-1:0] hh;
  logic [10:0]                z;
  logic [14:0]                u, acc_q14;
  logic [33:0]                s_raw;
  logic [14:0]                s_cap;
  logic signed [rch_pkg::TRIG_W-1:0] s_val;
  logic signed [AW-1:0]       acc_rnd;
  logic signed [13:0]         y1_diff;
  logic [13:0]                y1_mag;
  logic [50:0]                y1_prod;
  logic [DNW-1:0]             y1_q;
  logic [rch_pkg::HGT_W-1:0]  h_sat;
  logic [12:0]                ceil_v, floor_v;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // phase and magnitude of the current quarter-wave
  always_comb begin
    hh      = phase_r ? heading_r + rch_pkg::QUARTER_TURN : heading_r;
    z       = hh[10] ? 11'd1024 - {1'b0, hh[9:0]} : {1'b0, hh[9:0]};
    u       = {z[10:0], 4'b0};
    acc_q14 = acc[28:14];
    s_raw   = acc[47:14];
    s_cap   = (s_raw > 34'(rch_pkg::Q14_ONE)) ? rch_pkg::Q14_ONE : s_raw[14:0];
    s_val   = hh[11] ? -$signed({1'b0, s_cap}) : $signed({1'b0, s_cap});
    acc_rnd = (acc < 0) ? (acc + AW'(16383)) >>> 14 : acc >>> 14;
    y1_diff = $signed(14'(HALF_W)) - $signed({4'b0, col_r});
    y1_mag  = (y1_diff < 0) ? 14'(-y1_diff) : 14'(y1_diff);
    y1_prod = 51'(y1_mag) * 51'(Y1_RECIP);
    y1_q    = y1_prod[Y1_SHIFT +: DNW];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rch_pkg::S_IDLE:    if (in_fire) state_nxt = rch_pkg::S_Y1_GO;
      rch_pkg::S_Y1_GO:   state_nxt = rch_pkg::S_Y1_WAIT;
      rch_pkg::S_Y1_WAIT: state_nxt = rch_pkg::S_U2;
      rch_pkg::S_U2:      state_nxt = rch_pkg::S_U3;
      rch_pkg::S_U3:      state_nxt = rch_pkg::S_U5;
      rch_pkg::S_U5:      state_nxt = rch_pkg::S_S0;
      rch_pkg::S_S0:      state_nxt = rch_pkg::S_S1;
      rch_pkg::S_S1:      state_nxt = rch_pkg::S_S2;
      rch_pkg::S_S2:      state_nxt = rch_pkg::S_SEND;
      rch_pkg::S_SEND:    state_nxt = phase_r ? rch_pkg::S_VX0 : rch_pkg::S_U2;
      rch_pkg::S_VX0:     state_nxt = rch_pkg::S_VX1;
      rch_pkg::S_VX1:     state_nxt = rch_pkg::S_VY0;
      rch_pkg::S_VY0:     state_nxt = rch_pkg::S_VY1;
      rch_pkg::S_VY1:     state_nxt = rch_pkg::S_VEND;
      rch_pkg::S_VEND:    state_nxt = rch_pkg::S_M_GO;
      rch_pkg::S_M_GO:    state_nxt = rch_pkg::S_MARCH;
      rch_pkg::S_MARCH:   if (march_done) state_nxt = rch_pkg::S_H_GO;
      rch_pkg::S_H_GO:    state_nxt = rch_pkg::S_H_WAIT;
      rch_pkg::S_H_WAIT:  if (div_done) state_nxt = rch_pkg::S_FIN;
      rch_pkg::S_FIN:     if (out_free) state_nxt = rch_pkg::S_IDLE;
      default:            state_nxt = rch_pkg::S_IDLE;
    endcase
  end

  // unit controls and operands
  always_comb begin
    mac_op      = '{en: 1'b0, clr: 1'b0, sub: 1'b0};
    mac_a       = '0;
    mac_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    march_start = 1'b0;
    unique case (state_r)
      rch_pkg::S_U2: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(u));
        mac_b  = $signed(rch_pkg::MB_W'(u));
      end
      rch_pkg::S_U3: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(acc_q14));
        mac_b  = $signed(rch_pkg::MB_W'(u));
      end
      rch_pkg::S_U5: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(acc_q14));
        mac_b  = $signed(rch_pkg::MB_W'(u2_r));
      end
      rch_pkg::S_S0: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(rch_pkg::SIN_C1));
        mac_b  = $signed(rch_pkg::MB_W'(u));
      end
      rch_pkg::S_S1: begin
        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(rch_pkg::SIN_C5));
        mac_b  = $signed(rch_pkg::MB_W'(u5_r));
      end
      rch_pkg::S_S2: begin
        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a  = $signed(rch_pkg::MA_W'(rch_pkg::SIN_C3));
        mac_b  = $signed(rch_pkg::MB_W'(u3_r));
      end
      rch_pkg::S_VX0: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(rch_pkg::Q14_HALF));
        mac_b  = rch_pkg::MB_W'(cos_r);
      end
      rch_pkg::S_VX1: begin
        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a  = y1_r;
        mac_b  = rch_pkg::MB_W'(sin_r);
      end
      rch_pkg::S_VY0: begin
        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a  = $signed(rch_pkg::MA_W'(rch_pkg::Q14_HALF));
        mac_b  = rch_pkg::MB_W'(sin_r);
      end
      rch_pkg::S_VY1: begin
        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        mac_a  = y1_r;
        mac_b  = rch_pkg::MB_W'(cos_r);
      end
      // vy_r is loaded in S_VEND, so the march starts in the next state, S_M_GO
      rch_pkg::S_M_GO: march_start = 1'b1;
      rch_pkg::S_H_GO: begin
        div_start = 1'b1;
        div_num   = DNW'(SCREEN_HEIGHT * 50);
        div_den   = DDW'(steps);
      end
      default: ;
    endcase
  end

  // result shaping
  always_comb begin
    h_sat   = (hq_r > DNW'(rch_pkg::HGT_MAX)) ? rch_pkg::HGT_MAX : hq_r[11:0];
    ceil_v  = (13'(HALF_H) > {1'b0, h_sat}) ? 13'(HALF_H) - {1'b0, h_sat} : 13'd0;
    floor_v = 13'(HALF_H) + {1'b0, h_sat};
    if (floor_v > 13'(SCREEN_HEIGHT)) floor_v = 13'(SCREEN_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rch_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= rch_pkg::POS_RESET;
      pos_y_r     <= rch_pkg::POS_RESET;
      heading_r   <= rch_pkg::HEADING_RESET;
      phase_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rch_pkg::CFG_POS_X:   pos_x_r   <= cfg_wdata;
          rch_pkg::CFG_POS_Y:   pos_y_r   <= cfg_wdata;
          rch_pkg::CFG_HEADING: heading_r <= cfg_wdata[rch_pkg::HEAD_W-1:0];
          default: ;
        endcase
      end
      if (state_r == rch_pkg::S_Y1_WAIT) phase_r <= 1'b0;
      else if (state_r == rch_pkg::S_SEND) phase_r <= 1'b1;
      if (state_r == rch_pkg::S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) col_r <= in_ch.column;
    if (state_r == rch_pkg::S_Y1_GO)
      y1_r <= (y1_diff < 0) ? -$signed(y1_q) : $signed(y1_q);
    if (state_r == rch_pkg::S_U3) u2_r <= acc_q14;
    if (state_r == rch_pkg::S_U5) u3_r <= acc_q14;
    if (state_r == rch_pkg::S_S0) u5_r <= acc_q14;
    if (state_r == rch_pkg::S_SEND) begin
      if (phase_r) cos_r <= s_val;
      else         sin_r <= s_val;
    end
    if (state_r == rch_pkg::S_VY0)  vx_r <= acc_rnd[rch_pkg::VEC_W-1:0];
    if (state_r == rch_pkg::S_VEND) vy_r <= acc_rnd[rch_pkg::VEC_W-1:0];
    if (state_r == rch_pkg::S_H_WAIT && div_done) hq_r <= div_quo;
    if (state_r == rch_pkg::S_FIN && out_free) begin
      wall_height_r <= h_sat;
      ceiling_end_r <= ceil_v[rch_pkg::ROW_W-1:0];
      floor_start_r <= floor_v[rch_pkg::ROW_W-1:0];
      march_steps_r <= rch_pkg::STEP_W'(steps);
    end
  end

  rch_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  rch_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rch_march #(.MAX_STEPS(MAX_STEPS), .NW(NW)) u_march (
    .clk   (clk),
    .rst_n (rst_n),
    .start (march_start),
    .pos_x (pos_x_r),
    .pos_y (pos_y_r),
    .vx    (vx_r),
    .vy    (vy_r),
    .done  (march_done),
    .steps (steps)
  );

  assign in_ch.ready        = (state_r == rch_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.wall_height = wall_height_r;
  assign out_ch.ceiling_end = ceiling_end_r;
  assign out_ch.floor_start = floor_start_r;
  assign out_ch.march_steps = march_steps_r;
endmodule

@@ rtl/rch_checker.sv @@
// ----------------------------------------------------------------------------
// rch_checker
// Port-level checks of the raycast column block, bound to the top level.
// ----------------------------------------------------------------------------
`include "raycast_column_height_macros.svh"

module rch_checker #(
  parameter int HALF = 240
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rch_pkg::HGT_W-1:0]   wall_height,
  input logic [rch_pkg::ROW_W-1:0]   ceiling_end
);
  `RCH_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")
  `RCH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `RCH_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(wall_height), "result changed")
  `RCH_ASSERT(a_span, out_valid |-> (ceiling_end == '0) || (({3'b0, ceiling_end} + wall_height) == rch_pkg::HGT_W'(HALF)), "ceiling mismatch")
endmodule

bind raycast_column_height rch_checker #(.HALF(SCREEN_HEIGHT / 2)) u_rch_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .wall_height (out_ch.wall_height),
  .ceiling_end (out_ch.ceiling_end)
);
